// File: src/lru_recency_tracker_defines.svh
// assertion macros for the lru recency tracker
// used by the top level, which supplies clk and rst_n in scope
`ifndef LRU_RECENCY_TRACKER_DEFINES_SVH
`define LRU_RECENCY_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lrt_pkg.sv
// shared types and constants of the lru recency tracker
// no dependencies; used by the interfaces and the top level
package lrt_pkg;

    // tracker size and slot numbering
    localparam int ENTRIES    = 16;
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = 4;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int CAPACITY   = (ENTRIES < SLOT_COUNT) ? ENTRIES : SLOT_COUNT;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_TOUCH  = 2'd1,
        CMD_EVICT  = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_PRESENT = 3'd1,
        ST_ALREADY     = 3'd2,
        ST_FULL        = 3'd3,
        ST_EMPTY       = 3'd4
    } status_t;

endpackage

// File: src/lrt_if.sv
// valid/ready channel interfaces for the lru recency tracker
// depends on lrt_pkg for field widths

// command channel: one word per command
interface lrt_req_if import lrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output cmd, output slot, input ready);
    modport sink   (input valid, input cmd, input slot, output ready);
endinterface

// result channel: one word per command
interface lrt_rsp_if import lrt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   evicted_slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  occupancy;

    modport source (output valid, output evicted_slot, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input evicted_slot, input status, input occupancy,
                    output ready);
endinterface

// File: src/lru_recency_tracker.sv
// Least-recently-used recency tracker over sixteen cache slots.
// Channels: req carries a command word (cmd, slot); rsp returns one result
// word per command (evicted_slot, status, occupancy).
// Commands: insert adds an untracked slot as most recent, touch moves a
// tracked slot to most recent, evict removes the least recent slot and
// reports it. Status says ok, not present, already present, full or empty.
// The result word is registered and appears in the cycle after its command is taken.
// Throughput: one command per cycle unless rsp stalls; the rank update is a
// parallel compare and increment across the sixteen per-slot rank registers.
// The result register parts the two sides: a new command is taken while the
// result is being taken in the same cycle, so req.ready follows rsp.ready
// when a result is waiting and is high otherwise.
// When the receiver stalls, the result word holds and no command is taken.
// Reset clears all present flags, ranks and the slot count; no clearing
// pass is needed, and the block takes commands straight after reset.
// depends on lrt_pkg, lrt_if.sv and lru_recency_tracker_defines.svh
`include "lru_recency_tracker_defines.svh"

module lru_recency_tracker import lrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lrt_req_if.sink   req,
    lrt_rsp_if.source rsp
);

    // recency state
    logic [SLOT_W-1:0]   rank_reg    [SLOT_COUNT];
    logic [SLOT_W-1:0]   rank_next   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] present_reg;
    logic [SLOT_COUNT-1:0] present_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    // result register
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [SLOT_W-1:0]   evicted_reg;
    logic [SLOT_W-1:0]   evicted_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    // working signals
    logic                accept;
    logic [SLOT_W-1:0]   touch_rank;
    logic [SLOT_W-1:0]   last_rank;
    logic [SLOT_W-1:0]   victim;
    logic                victim_found;

    // handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // rank of the requested slot and of the least recent slot; a full tracker wraps to the top rank
    assign touch_rank = rank_reg[req.slot];
    assign last_rank  = count_reg[SLOT_W-1:0] - SLOT_W'(1);

    // least recent slot search, lowest slot number wins
    always_comb
    begin
        victim       = '0;
        victim_found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (present_reg[i] && (rank_reg[i] == last_rank))
            begin
                victim       = SLOT_W'(i);
                victim_found = 1'b1;
            end
        end
    end

    // command decode and state update
    always_comb
    begin
        rank_next    = rank_reg;
        present_next = present_reg;
        count_next   = count_reg;
        evicted_next = '0;
        status_next  = ST_OK;

        unique case (req.cmd)
            CMD_INSERT:
            begin
                if (present_reg[req.slot])
                begin
                    status_next = ST_ALREADY;
                end
                else if (count_reg >= COUNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (present_reg[i])
                        begin
                            rank_next[i] = rank_reg[i] + SLOT_W'(1);
                        end
                    end
                    rank_next[req.slot]    = '0;
                    present_next[req.slot] = 1'b1;
                    count_next             = count_reg + COUNT_W'(1);
                end
            end
            CMD_TOUCH:
            begin
                if (!present_reg[req.slot])
                begin
                    status_next = ST_NOT_PRESENT;
                end
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (present_reg[i] && (rank_reg[i] < touch_rank))
                        begin
                            rank_next[i] = rank_reg[i] + SLOT_W'(1);
                        end
                    end
                    rank_next[req.slot] = '0;
                end
            end
            CMD_EVICT:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    if (victim_found)
                    begin
                        evicted_next          = victim;
                        present_next[victim]  = 1'b0;
                        rank_next[victim]     = '0;
                    end
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                // unused code leaves the state alone
                status_next = ST_OK;
            end
        endcase
    end

    // result valid tracking
    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control and recency state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                rank_reg[i] <= '0;
            end
            present_reg   <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                rank_reg    <= rank_next;
                present_reg <= present_next;
                count_reg   <= count_next;
            end
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            evicted_reg <= evicted_next;
            status_reg  <= status_next;
        end
    end

    // result word
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.evicted_slot = evicted_reg;
    assign rsp.status       = status_reg;
    assign rsp.occupancy    = count_reg;

    // checks
    `LRT_ASSERT_NOW(a_count_matches_flags, 1'b1, $countones(present_reg) == count_reg,
        "slot count differs from number of present flags")
    `LRT_ASSERT_NOW(a_occupancy_in_range, rsp_valid_reg, count_reg <= COUNT_W'(CAPACITY),
        "occupancy above capacity")
    `LRT_ASSERT_NEXT(a_accept_gives_result, accept, rsp_valid_reg,
        "accepted command produced no result word")

endmodule
